FILE: rtl/core/pla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// pla_pkg: shared widths, defaults and result codes of the priority lock arbiter
// no dependencies; imported by the core and its checker

package pla_pkg;

    localparam int ID_W         = 6;
    localparam int MAP_W        = 2 ** ID_W;
    localparam int CNT_W        = 7;
    localparam int PLA_ID_SPACE = 64;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_QUEUED   = 2'd1,
        ST_RELEASED = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef enum logic {
        FN_ACQUIRE = 1'b0,
        FN_RELEASE = 1'b1
    } func_t;

endpackage

`default_nettype wire

FILE: rtl/core/priority_lock_arbiter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Priority lock arbiter: a mutual-exclusion lock whose waiters are served highest id
// first. Acquire and release requests arrive as beats on the req channel (func, requester_id).
// Each request gives exactly one beat on the rsp channel, with the status, any grant made,
// and the lock state after the request. A free lock is granted at once. A busy lock puts
// the requester in a waiting bitmap. A release frees the lock and passes it in the same
// step to the highest waiting id. Repeat requests, out-of-range ids and releases of a free lock are rejected.
// Timing: one request a cycle while req_stall is low. A request is held in the input
// register. The decision (bitmap test, six-level priority encoder, counter update) is made
// between that register and the result register, which then drives the response. The
// waiting set clears at reset and needs no clearing pass.
// Depends on pla_pkg.

module priority_lock_arbiter_core
    import pla_pkg::*;
#(
    parameter int ID_SPACE = PLA_ID_SPACE
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire logic              func,
    input  wire logic [ID_W-1:0]   requester_id,
    // response channel
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic [1:0]             status,
    output logic                   grant_valid,
    output logic [ID_W-1:0]        grant_id,
    output logic                   lock_held,
    output logic [ID_W-1:0]        holder_id,
    output logic                   requester_holds,
    output logic [CNT_W-1:0]       waiting_count
);

    // only ids representable on the port can ever wait
    localparam int SET_BITS = (ID_SPACE < MAP_W) ? ID_SPACE : MAP_W;

    // highest set bit of the bitmap by successive halving, one index bit per level
    function automatic logic [ID_W-1:0] highest_id(input logic [MAP_W-1:0] vec);
        logic [MAP_W-1:0] win;
        logic [MAP_W-1:0] hi;
        logic [MAP_W-1:0] lo;
        logic [MAP_W-1:0] low_mask;
        logic [ID_W-1:0]  idx;
        int               half;
        win = vec;
        idx = '0;
        for (int b = ID_W - 1; b >= 0; b--)
        begin
            half     = 1 << b;
            low_mask = (MAP_W'(1) << half) - MAP_W'(1);
            hi       = (win >> half) & low_mask;
            lo       = win & low_mask;
            if (hi != '0)
            begin
                idx[b] = 1'b1;
                win    = hi;
            end
            else
            begin
                win = lo;
            end
        end
        return idx;
    endfunction

    // input register
    logic              s1_valid_reg, s1_valid_next;
    func_t             func_reg;
    logic [ID_W-1:0]   id_reg;

    // lock state
    logic                held_reg,   held_next;
    logic [ID_W-1:0]     holder_reg, holder_next;
    logic [SET_BITS-1:0] set_reg,    set_next;
    logic [CNT_W-1:0]    count_reg,  count_next;

    // result register
    logic              rsp_valid_reg, rsp_valid_next;
    status_t           status_reg,    status_next;
    logic              gvalid_reg,    gvalid_next;
    logic [ID_W-1:0]   gid_reg,       gid_next;
    logic              rholds_reg,    rholds_next;

    logic              req_take;
    logic              advance;
    logic              in_range;
    logic              hold_hit;
    logic              wait_hit;
    logic [MAP_W-1:0]  map_cur;
    logic [MAP_W-1:0]  map_new;
    logic [ID_W-1:0]   top_id;

    // the input beat moves on when the result slot is free or being emptied
    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    assign s1_valid_next  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign rsp_valid_next = advance ? 1'b1 : (rsp_valid_reg && rsp_stall);

    assign map_cur  = MAP_W'(set_reg);
    assign in_range = (32'(id_reg) < ID_SPACE);
    assign hold_hit = held_reg && (holder_reg == id_reg);
    assign wait_hit = map_cur[id_reg];
    assign top_id   = highest_id(map_cur);

    // decision for the beat in the input register
    always_comb
    begin
        held_next   = held_reg;
        holder_next = holder_reg;
        map_new     = map_cur;
        count_next  = count_reg;
        status_next = ST_REJECTED;
        gvalid_next = 1'b0;
        gid_next    = '0;
        if (func_reg == FN_ACQUIRE)
        begin
            priority if (!in_range || hold_hit || wait_hit)
            begin
                status_next = ST_REJECTED;
            end
            else if (!held_reg)
            begin
                held_next   = 1'b1;
                holder_next = id_reg;
                status_next = ST_GRANTED;
                gvalid_next = 1'b1;
                gid_next    = id_reg;
            end
            else
            begin
                map_new[id_reg] = 1'b1;
                count_next      = count_reg + CNT_W'(1);
                status_next     = ST_QUEUED;
            end
        end
        else if (held_reg)
        begin
            // release: free, then hand straight on to the top waiter
            held_next   = 1'b0;
            holder_next = '0;
            status_next = ST_RELEASED;
            if (count_reg != '0)
            begin
                map_new[top_id] = 1'b0;
                count_next      = count_reg - CNT_W'(1);
                held_next       = 1'b1;
                holder_next     = top_id;
                gvalid_next     = 1'b1;
                gid_next        = top_id;
            end
        end
        set_next    = map_new[SET_BITS-1:0];
        rholds_next = held_next && (holder_next == id_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            held_reg      <= 1'b0;
            holder_reg    <= '0;
            set_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                held_reg   <= held_next;
                holder_reg <= holder_next;
                set_reg    <= set_next;
                count_reg  <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            func_reg <= func_t'(func);
            id_reg   <= requester_id;
        end
        if (advance)
        begin
            status_reg <= status_next;
            gvalid_reg <= gvalid_next;
            gid_reg    <= gid_next;
            rholds_reg <= rholds_next;
        end
    end

    // lock state after the step travels out with the result
    logic              held_out_reg;
    logic [ID_W-1:0]   holder_out_reg;
    logic [CNT_W-1:0]  count_out_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            held_out_reg   <= held_next;
            holder_out_reg <= holder_next;
            count_out_reg  <= count_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign grant_valid     = gvalid_reg;
    assign grant_id        = gid_reg;
    assign lock_held       = held_out_reg;
    assign holder_id       = holder_out_reg;
    assign requester_holds = rholds_reg;
    assign waiting_count   = count_out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pla_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// pla_checker: port-level assertions on the priority lock arbiter core
// depends on pla_pkg; bound to priority_lock_arbiter_core below

module pla_checker
    import pla_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire logic [1:0]        status,
    input  wire logic              grant_valid,
    input  wire logic [ID_W-1:0]   grant_id,
    input  wire logic              lock_held,
    input  wire logic [ID_W-1:0]   holder_id,
    input  wire logic [CNT_W-1:0]  waiting_count
);

    // a grant leaves the grantee holding the lock
    a_grant_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && grant_valid |-> lock_held && (holder_id == grant_id))
        else $error("grant not reflected in holder");

    // a free lock never has waiters
    a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !lock_held |-> (waiting_count == '0) && (holder_id == '0))
        else $error("free lock with waiters or stale holder");

    // queueing only happens behind a holder and grants nothing
    a_queue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_QUEUED) |-> lock_held && !grant_valid
                                             && (waiting_count != '0))
        else $error("queued beat with lock free or a grant");

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(grant_id)
                                   && $stable(waiting_count))
        else $error("stalled response changed");

endmodule

bind priority_lock_arbiter_core pla_checker u_pla_checker (.*);

`default_nettype wire
